>>> rtl/svcs_pkg.sv
`default_nettype none

package svcs_pkg;

    // Field widths
    localparam int AXIS_W   = 16;
    localparam int GAIN_W   = 16;
    localparam int LIMIT_W  = 23;
    localparam int TIME_W   = 32;
    localparam int AXES_W   = 4;
    localparam int CMD_W    = 24;
    localparam int IN_DW    = 72;
    localparam int OUT_DW   = 48;

    // Configuration port
    localparam int CFG_AW   = 5;
    localparam int CFG_DW   = 32;

    // Unsigned domain wide enough for any limit, gain product or speed magnitude
    localparam int WORK_W   = 33;
    // |axis| * gain >> 15
    localparam int MAG_W    = 18;
    localparam int AXIS_FRAC = 15;

    // floor(x / 1000) = floor(floor(x / 8) / 125)
    localparam int MS_PER_S   = 1000;
    localparam int DIV_SHIFT  = 3;
    localparam int DIV_ODD    = 125;
    localparam int DIV_ODD_LOG = 7;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic [AXES_W-1:0] MIN_FWD_AXES  = 4'd1;
    localparam logic [AXES_W-1:0] MIN_TURN_AXES = 4'd3;

    typedef enum logic [2:0] {
        REG_FWD_LIMIT  = 3'd0,
        REG_TURN_LIMIT = 3'd1,
        REG_FWD_ACCEL  = 3'd2,
        REG_TURN_ACCEL = 3'd3,
        REG_DEADZONE   = 3'd4,
        REG_FWD_GAIN   = 3'd5,
        REG_TURN_GAIN  = 3'd6,
        REG_THRESHOLD  = 3'd7
    } svcs_reg_t;

    localparam logic [LIMIT_W-1:0] RST_FWD_LIMIT  = 23'd65536;
    localparam logic [LIMIT_W-1:0] RST_TURN_LIMIT = 23'd327680;
    localparam logic [LIMIT_W-1:0] RST_FWD_ACCEL  = 23'd52429;
    localparam logic [LIMIT_W-1:0] RST_TURN_ACCEL = 23'd131072;
    localparam logic [AXIS_W-1:0]  RST_DEADZONE   = 16'd6554;
    localparam logic [GAIN_W-1:0]  RST_FWD_GAIN   = 16'd21845;
    localparam logic [GAIN_W-1:0]  RST_TURN_GAIN  = 16'd16384;
    localparam logic [LIMIT_W-1:0] RST_THRESHOLD  = 23'd66;

    // Pipeline advance enables, one per stage after the input register
    typedef struct packed {
        logic p2;
        logic p3;
        logic p4;
        logic p5;
    } svcs_adv_t;

endpackage

`default_nettype wire

>>> rtl/svcs_axis_target.sv
`default_nettype none

module svcs_axis_target #(
    parameter int SPEED_WIDTH = 24
) (
    input  wire logic                                   aclk,
    input  wire svcs_pkg::svcs_adv_t                    adv,
    input  wire logic                                   present,
    input  wire logic signed [svcs_pkg::AXIS_W-1:0]     axis,
    input  wire logic        [svcs_pkg::AXIS_W-1:0]     deadzone,
    input  wire logic        [svcs_pkg::GAIN_W-1:0]     gain,
    input  wire logic        [svcs_pkg::LIMIT_W-1:0]    limit,
    output logic signed      [SPEED_WIDTH-1:0]          target
);
    import svcs_pkg::*;

    localparam int AMAG_W = AXIS_W + 1;
    localparam int PROD_W = AMAG_W + GAIN_W;
    localparam logic [WORK_W-1:0] SPEED_MAX = WORK_W'((64'd1 << (SPEED_WIDTH - 1)) - 64'd1);

    logic [AMAG_W-1:0] amag;
    logic [PROD_W-1:0] prod;
    logic              zero_next;

    logic              neg_reg;
    logic              zero_reg;
    logic [PROD_W-1:0] prod_reg;

    logic [MAG_W-1:0]  mag;
    logic [WORK_W-1:0] lim_w;
    logic [WORK_W-1:0] mag_w;
    logic [WORK_W-1:0] res_w;
    logic [WORK_W-1:0] tgt_w;

    logic signed [SPEED_WIDTH-1:0] target_reg;

    assign amag      = axis[AXIS_W-1] ? (AMAG_W'(0) - AMAG_W'(axis)) : AMAG_W'(axis);
    assign zero_next = !present || (amag < {1'b0, deadzone});
    assign prod      = amag * gain;

    always_ff @(posedge aclk) begin
        if (adv.p2) begin
            neg_reg  <= axis[AXIS_W-1];
            zero_reg <= zero_next;
            prod_reg <= prod;
        end
    end

    // Clamp to the smaller of the written limit and the largest speed
    assign mag   = prod_reg[AXIS_FRAC +: MAG_W];
    assign lim_w = (WORK_W'(limit) > SPEED_MAX) ? SPEED_MAX : WORK_W'(limit);
    assign mag_w = WORK_W'(mag);
    assign res_w = (mag_w > lim_w) ? lim_w : mag_w;
    assign tgt_w = zero_reg ? '0 : (neg_reg ? (WORK_W'(0) - res_w) : res_w);

    always_ff @(posedge aclk) begin
        if (adv.p3) begin
            target_reg <= tgt_w[SPEED_WIDTH-1:0];
        end
    end

    assign target = target_reg;

endmodule

`default_nettype wire

>>> rtl/svcs_slew_step.sv
`default_nettype none

module svcs_slew_step #(
    parameter int SPEED_WIDTH = 24
) (
    input  wire logic                                aclk,
    input  wire svcs_pkg::svcs_adv_t                 adv,
    input  wire logic [svcs_pkg::TIME_W-1:0]         dt,
    input  wire logic [svcs_pkg::LIMIT_W-1:0]        accel,
    output logic      [SPEED_WIDTH-1:0]              step,
    output logic                                     step_zero,
    output logic                                     step_big
);
    import svcs_pkg::*;

    localparam int PROD_W = LIMIT_W + TIME_W;
    // Below the saturation point accel*dt/8 fits Y_W bits
    localparam int Y_W    = SPEED_WIDTH + DIV_ODD_LOG;
    localparam int YL_W   = Y_W / 2;
    localparam int YH_W   = Y_W - YL_W;
    localparam int SH     = Y_W + DIV_ODD_LOG;
    localparam int RW     = SH - 6;
    localparam int PH_W   = YH_W + RW;
    localparam int PL_W   = YL_W + RW;
    localparam int FULL_W = Y_W + RW;
    localparam logic [RW-1:0] RECIP =
        RW'(((64'd1 << SH) + 64'd124) / 64'd125);
    localparam logic [PROD_W-1:0] BIG_LIM = PROD_W'(64'd1000 << SPEED_WIDTH);

    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] prod_reg;

    logic [Y_W-1:0]    y;
    logic [PH_W-1:0]   ph;
    logic [PL_W-1:0]   pl;
    logic [PH_W-1:0]   ph_reg;
    logic [PL_W-1:0]   pl_reg;
    logic              zero4_reg;
    logic              big4_reg;

    logic [FULL_W-1:0] full;
    logic [SPEED_WIDTH-1:0] step_reg;
    logic              zero5_reg;
    logic              big5_reg;

    assign prod = accel * dt;

    always_ff @(posedge aclk) begin
        if (adv.p3) begin
            prod_reg <= prod;
        end
    end

    // Reciprocal multiply by 1/125, split in two partial products
    assign y  = prod_reg[DIV_SHIFT +: Y_W];
    assign ph = y[Y_W-1:YL_W] * RECIP;
    assign pl = y[YL_W-1:0] * RECIP;

    always_ff @(posedge aclk) begin
        if (adv.p4) begin
            ph_reg    <= ph;
            pl_reg    <= pl;
            zero4_reg <= (prod_reg == '0);
            big4_reg  <= (prod_reg >= BIG_LIM);
        end
    end

    assign full = (FULL_W'(ph_reg) << YL_W) + FULL_W'(pl_reg);

    always_ff @(posedge aclk) begin
        if (adv.p5) begin
            step_reg  <= full[SH +: SPEED_WIDTH];
            zero5_reg <= zero4_reg;
            big5_reg  <= big4_reg;
        end
    end

    assign step      = step_reg;
    assign step_zero = zero5_reg;
    assign step_big  = big5_reg;

endmodule

`default_nettype wire

>>> rtl/stick_velocity_command_shaper.sv
`default_nettype none
// Channel   Dir  tdata (low bit up)                                   tuser
// s_        in   time_ms[31:0] stick_forward[47:32] stick_turn[63:48]  opcode
//                axes_count[67:64] stop_button[68] zero[71:69]
// m_        out  forward_cmd[23:0] turn_cmd[47:24]                    is_stop
// apb       in   registers at 4*i, 32-bit data, pready tied high
//
// One item per cycle while no stall on m_ backs up the stages. An accepted item passes
// the input register, then gain and deadzone, accel*dt, the two partial products of the
// divide by 1000, and the slew/emit stage that owns the speed state.
// An item that makes no result leaves the last stage even while a result waits.
// Stalls on m_ back up through the stages; s_tready drops only when all are full.
// aresetn (synchronous) loads the register defaults and clears speeds and valid bits.

module stick_velocity_command_shaper #(
    parameter int SPEED_WIDTH = 24
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // time_ms, stick_forward, stick_turn, axes_count, stop_button, pad
    input  wire logic [svcs_pkg::IN_DW-1:0]         s_tdata,
    // opcode
    input  wire logic                               s_tuser,

    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // forward_cmd, turn_cmd
    output logic [svcs_pkg::OUT_DW-1:0]             m_tdata,
    // is_stop
    output logic                                    m_tuser,

    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [svcs_pkg::CFG_AW-1:0]        paddr,
    input  wire logic [svcs_pkg::CFG_DW-1:0]        pwdata,
    output logic [svcs_pkg::CFG_DW-1:0]             prdata,
    output logic                                    pready
);
    import svcs_pkg::*;

    localparam int DW = SPEED_WIDTH + 2;
    localparam int CW = (DW > LIMIT_W + 1) ? DW : LIMIT_W + 1;

    typedef logic signed [SPEED_WIDTH-1:0] speed_t;

    // Configuration
    logic [LIMIT_W-1:0] fwd_limit_reg, turn_limit_reg;
    logic [LIMIT_W-1:0] fwd_accel_reg, turn_accel_reg;
    logic [AXIS_W-1:0]  deadzone_reg;
    logic [GAIN_W-1:0]  fwd_gain_reg, turn_gain_reg;
    logic [LIMIT_W-1:0] threshold_reg;
    logic               cfg_wr;
    svcs_reg_t          cfg_sel;

    // Pipeline
    svcs_adv_t          adv;
    logic               v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic               op1_reg, op2_reg, op3_reg, op4_reg, op5_reg;
    logic               stop1_reg, stop2_reg, stop3_reg, stop4_reg, stop5_reg;
    logic [TIME_W-1:0]  time1_reg;
    logic signed [AXIS_W-1:0] fwd1_reg, turn1_reg;
    logic [AXES_W-1:0]  axes1_reg;
    logic [TIME_W-1:0]  last_time_reg;
    logic [TIME_W-1:0]  dt2_reg;
    speed_t             tf3, tt3;
    speed_t             tf4_reg, tt4_reg, tf5_reg, tt5_reg;
    logic [SPEED_WIDTH-1:0] step_f, step_t;
    logic               zero_f, zero_t, big_f, big_t;

    // Speed state
    speed_t             tgt_f_reg, tgt_t_reg, cur_f_reg, cur_t_reg;
    speed_t             emit_f_reg, emit_t_reg;
    logic               prev_btn_reg;
    speed_t             tgt_f_next, tgt_t_next, cur_f_next, cur_t_next;
    speed_t             emit_f_next, emit_t_next;
    logic               prev_btn_next;

    speed_t             slew_f, slew_t;
    logic               below_f, below_t;
    logic               emit5, can5, fire5, out_free;

    // Result register
    logic               out_v_reg, out_v_next;
    logic [CMD_W-1:0]   out_fwd_reg, out_fwd_next, out_turn_reg, out_turn_next;
    logic               out_stop_reg, out_stop_next;

    function automatic speed_t slew_next(
        input speed_t                 cur,
        input speed_t                 tgt,
        input logic [SPEED_WIDTH-1:0] step,
        input logic                   zero,
        input logic                   big
    );
        logic signed [DW-1:0] delta;
        logic signed [DW-1:0] step_s;
        logic signed [DW-1:0] res;
        delta  = DW'(tgt) - DW'(cur);
        step_s = DW'({2'b00, step});
        if (zero || big) begin
            res = DW'(tgt);
        end else if (delta > step_s) begin
            res = DW'(cur) + step_s;
        end else if (delta < -step_s) begin
            res = DW'(cur) - step_s;
        end else begin
            res = DW'(tgt);
        end
        return res[SPEED_WIDTH-1:0];
    endfunction

    function automatic logic under_thr(
        input speed_t             a,
        input speed_t             b,
        input logic [LIMIT_W-1:0] thr
    );
        logic signed [DW-1:0] diff;
        logic [DW-1:0]        mag;
        diff = DW'(a) - DW'(b);
        mag  = diff[DW-1] ? DW'(-diff) : DW'(diff);
        return CW'(mag) < CW'(thr);
    endfunction

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = svcs_reg_t'(paddr[CFG_AW-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_limit_reg  <= RST_FWD_LIMIT;
            turn_limit_reg <= RST_TURN_LIMIT;
            fwd_accel_reg  <= RST_FWD_ACCEL;
            turn_accel_reg <= RST_TURN_ACCEL;
            deadzone_reg   <= RST_DEADZONE;
            fwd_gain_reg   <= RST_FWD_GAIN;
            turn_gain_reg  <= RST_TURN_GAIN;
            threshold_reg  <= RST_THRESHOLD;
        end else if (cfg_wr) begin
            unique case (cfg_sel)
                REG_FWD_LIMIT:  fwd_limit_reg  <= pwdata[LIMIT_W-1:0];
                REG_TURN_LIMIT: turn_limit_reg <= pwdata[LIMIT_W-1:0];
                REG_FWD_ACCEL:  fwd_accel_reg  <= pwdata[LIMIT_W-1:0];
                REG_TURN_ACCEL: turn_accel_reg <= pwdata[LIMIT_W-1:0];
                REG_DEADZONE:   deadzone_reg   <= pwdata[AXIS_W-1:0];
                REG_FWD_GAIN:   fwd_gain_reg   <= pwdata[GAIN_W-1:0];
                REG_TURN_GAIN:  turn_gain_reg  <= pwdata[GAIN_W-1:0];
                REG_THRESHOLD:  threshold_reg  <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            REG_FWD_LIMIT:  prdata = CFG_DW'(fwd_limit_reg);
            REG_TURN_LIMIT: prdata = CFG_DW'(turn_limit_reg);
            REG_FWD_ACCEL:  prdata = CFG_DW'(fwd_accel_reg);
            REG_TURN_ACCEL: prdata = CFG_DW'(turn_accel_reg);
            REG_DEADZONE:   prdata = CFG_DW'(deadzone_reg);
            REG_FWD_GAIN:   prdata = CFG_DW'(fwd_gain_reg);
            REG_TURN_GAIN:  prdata = CFG_DW'(turn_gain_reg);
            REG_THRESHOLD:  prdata = CFG_DW'(threshold_reg);
            default:        prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    assign out_free = !out_v_reg || m_tready;
    assign can5     = !emit5 || out_free;
    assign fire5    = v5_reg && can5;
    assign adv.p5   = !v5_reg || can5;
    assign adv.p4   = !v4_reg || adv.p5;
    assign adv.p3   = !v3_reg || adv.p4;
    assign adv.p2   = !v2_reg || adv.p3;
    assign s_tready = !v1_reg || adv.p2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            last_time_reg <= '0;
        end else begin
            if (s_tready) v1_reg <= s_tvalid;
            if (adv.p2)   v2_reg <= v1_reg;
            if (adv.p3)   v3_reg <= v2_reg;
            if (adv.p4)   v4_reg <= v3_reg;
            if (adv.p5)   v5_reg <= v4_reg;
            // elapsed time is measured between consecutive ticks
            if (v1_reg && adv.p2 && op1_reg == OP_TICK) begin
                last_time_reg <= time1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            op1_reg   <= s_tuser;
            time1_reg <= s_tdata[31:0];
            fwd1_reg  <= s_tdata[47:32];
            turn1_reg <= s_tdata[63:48];
            axes1_reg <= s_tdata[67:64];
            stop1_reg <= s_tdata[68];
        end
        if (adv.p2) begin
            op2_reg   <= op1_reg;
            stop2_reg <= stop1_reg;
            dt2_reg   <= time1_reg - last_time_reg;
        end
        if (adv.p3) begin
            op3_reg   <= op2_reg;
            stop3_reg <= stop2_reg;
        end
        if (adv.p4) begin
            op4_reg   <= op3_reg;
            stop4_reg <= stop3_reg;
            tf4_reg   <= tf3;
            tt4_reg   <= tt3;
        end
        if (adv.p5) begin
            op5_reg   <= op4_reg;
            stop5_reg <= stop4_reg;
            tf5_reg   <= tf4_reg;
            tt5_reg   <= tt4_reg;
        end
    end

    svcs_axis_target #(.SPEED_WIDTH(SPEED_WIDTH)) u_fwd_target (
        .aclk     (aclk),
        .adv      (adv),
        .present  (axes1_reg > MIN_FWD_AXES),
        .axis     (fwd1_reg),
        .deadzone (deadzone_reg),
        .gain     (fwd_gain_reg),
        .limit    (fwd_limit_reg),
        .target   (tf3)
    );

    svcs_axis_target #(.SPEED_WIDTH(SPEED_WIDTH)) u_turn_target (
        .aclk     (aclk),
        .adv      (adv),
        .present  (axes1_reg > MIN_TURN_AXES),
        .axis     (turn1_reg),
        .deadzone (deadzone_reg),
        .gain     (turn_gain_reg),
        .limit    (turn_limit_reg),
        .target   (tt3)
    );

    svcs_slew_step #(.SPEED_WIDTH(SPEED_WIDTH)) u_fwd_step (
        .aclk      (aclk),
        .adv       (adv),
        .dt        (dt2_reg),
        .accel     (fwd_accel_reg),
        .step      (step_f),
        .step_zero (zero_f),
        .step_big  (big_f)
    );

    svcs_slew_step #(.SPEED_WIDTH(SPEED_WIDTH)) u_turn_step (
        .aclk      (aclk),
        .adv       (adv),
        .dt        (dt2_reg),
        .accel     (turn_accel_reg),
        .step      (step_t),
        .step_zero (zero_t),
        .step_big  (big_t)
    );

    // ---------------- slew and emit stage ----------------
    assign slew_f  = slew_next(cur_f_reg, tgt_f_reg, step_f, zero_f, big_f);
    assign slew_t  = slew_next(cur_t_reg, tgt_t_reg, step_t, zero_t, big_t);
    assign below_f = under_thr(slew_f, emit_f_reg, threshold_reg);
    assign below_t = under_thr(slew_t, emit_t_reg, threshold_reg);
    assign emit5   = v5_reg && ((op5_reg == OP_SAMPLE) ? prev_btn_reg : !(below_f && below_t));

    always_comb begin
        tgt_f_next    = tgt_f_reg;
        tgt_t_next    = tgt_t_reg;
        cur_f_next    = cur_f_reg;
        cur_t_next    = cur_t_reg;
        emit_f_next   = emit_f_reg;
        emit_t_next   = emit_t_reg;
        prev_btn_next = prev_btn_reg;
        if (fire5) begin
            if (op5_reg == OP_SAMPLE) begin
                prev_btn_next = stop5_reg;
                if (prev_btn_reg) begin
                    // stop button held on the previous sample: drop targets and current speeds to zero
                    tgt_f_next = '0;
                    tgt_t_next = '0;
                    cur_f_next = '0;
                    cur_t_next = '0;
                end else begin
                    tgt_f_next = tf5_reg;
                    tgt_t_next = tt5_reg;
                end
            end else begin
                cur_f_next = slew_f;
                cur_t_next = slew_t;
                if (emit5) begin
                    emit_f_next = slew_f;
                    emit_t_next = slew_t;
                end
            end
        end
    end

    always_comb begin
        out_v_next    = out_v_reg;
        out_fwd_next  = out_fwd_reg;
        out_turn_next = out_turn_reg;
        out_stop_next = out_stop_reg;
        if (fire5 && emit5) begin
            out_v_next    = 1'b1;
            out_stop_next = (op5_reg == OP_SAMPLE);
            if (op5_reg == OP_SAMPLE) begin
                out_fwd_next  = '0;
                out_turn_next = '0;
            end else begin
                out_fwd_next  = CMD_W'(slew_f);
                out_turn_next = CMD_W'(slew_t);
            end
        end else if (m_tready) begin
            out_v_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tgt_f_reg    <= '0;
            tgt_t_reg    <= '0;
            cur_f_reg    <= '0;
            cur_t_reg    <= '0;
            emit_f_reg   <= '0;
            emit_t_reg   <= '0;
            prev_btn_reg <= 1'b0;
            out_v_reg    <= 1'b0;
        end else begin
            tgt_f_reg    <= tgt_f_next;
            tgt_t_reg    <= tgt_t_next;
            cur_f_reg    <= cur_f_next;
            cur_t_reg    <= cur_t_next;
            emit_f_reg   <= emit_f_next;
            emit_t_reg   <= emit_t_next;
            prev_btn_reg <= prev_btn_next;
            out_v_reg    <= out_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_fwd_reg  <= out_fwd_next;
        out_turn_reg <= out_turn_next;
        out_stop_reg <= out_stop_next;
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {out_turn_reg, out_fwd_reg};
    assign m_tuser  = out_stop_reg;

endmodule

`default_nettype wire

>>> rtl/svcs_port_checker.sv
`default_nettype none

module svcs_port_checker (
    input wire logic                               aclk,
    input wire logic                               aresetn,
    input wire logic                               s_tready,
    input wire logic                               m_tvalid,
    input wire logic                               m_tready,
    input wire logic [svcs_pkg::OUT_DW-1:0]        m_tdata,
    input wire logic                               m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a stop command always carries zero speeds
    a_stop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("stop command with nonzero speed");

    // with the result register empty nothing can block the input side
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind stick_velocity_command_shaper svcs_port_checker u_svcs_port_checker (.*);

`default_nettype wire
